### src/imu_quaternion_fusion_step_defines.svh
// Assertion helpers shared by the checker
`ifndef IMU_QUATERNION_FUSION_STEP_DEFINES_SVH
`define IMU_QUATERNION_FUSION_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define IQFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IQFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/iqfs_pkg.sv
package iqfs_pkg;

  typedef logic [4:0] slot_t;

  // register file slots
  localparam slot_t SL_QW   = 5'd0;
  localparam slot_t SL_QX   = 5'd1;
  localparam slot_t SL_QY   = 5'd2;
  localparam slot_t SL_QZ   = 5'd3;
  localparam slot_t SL_A0   = 5'd4;
  localparam slot_t SL_A1   = 5'd5;
  localparam slot_t SL_A2   = 5'd6;
  localparam slot_t SL_F1   = 5'd7;
  localparam slot_t SL_F2   = 5'd8;
  localparam slot_t SL_F3   = 5'd9;
  localparam slot_t SL_S0   = 5'd10;
  localparam slot_t SL_S1   = 5'd11;
  localparam slot_t SL_S2   = 5'd12;
  localparam slot_t SL_S3   = 5'd13;
  localparam slot_t SL_R0   = 5'd14;
  localparam slot_t SL_R1   = 5'd15;
  localparam slot_t SL_R2   = 5'd16;
  localparam slot_t SL_R3   = 5'd17;
  localparam slot_t SL_D0   = 5'd18;
  localparam slot_t SL_D1   = 5'd19;
  localparam slot_t SL_D2   = 5'd20;
  localparam slot_t SL_D3   = 5'd21;
  // integrated quaternion overwrites the derivative slots in place
  localparam slot_t SL_N0   = SL_D0;
  localparam slot_t SL_GX   = 5'd22;
  localparam slot_t SL_GY   = 5'd23;
  localparam slot_t SL_GZ   = 5'd24;
  localparam slot_t SL_BETA = 5'd25;
  localparam slot_t SL_PER  = 5'd26;
  localparam slot_t SL_AX   = 5'd27;
  localparam slot_t SL_AY   = 5'd28;
  localparam slot_t SL_AZ   = 5'd29;
  localparam slot_t SL_ZERO = 5'd30;
  localparam int    NSLOT   = 31;

  localparam logic [7:0] REG_GAIN_BETA     = 8'd0;
  localparam logic [7:0] REG_SAMPLE_PERIOD = 8'd1;

  localparam logic [15:0] BETA_RST   = 16'd6554;
  localparam logic [23:0] PERIOD_RST = 24'd16777;

  localparam logic [4:0] OP_LAST1  = 5'd6;
  localparam logic [4:0] OP_FIRST2 = 5'd7;
  localparam logic [4:0] OP_LAST2  = 5'd18;

  typedef struct packed {
    logic       en;
    slot_t      a;
    slot_t      b;
    logic [4:0] sh;
    logic       neg;
    logic       dbl;
  } term_t;

  typedef struct packed {
    term_t [2:0] t;
    logic [4:0]  post_sh;
    logic        post_neg;
    slot_t       add;
    logic        add_neg;
    logic        add_one;
    slot_t       dst;
  } op_t;

  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  localparam term_t TNONE = '0;

  // round to nearest, ties up
  function automatic logic signed [71:0] rshr72(input logic signed [71:0] v,
                                                input logic [4:0] s);
    logic signed [71:0] r;
    if (s == 5'd0) begin
      r = v;
    end else begin
      r = (v + (72'sd1 <<< (s - 5'd1))) >>> s;
    end
    return r;
  endfunction

  function automatic term_t tm(input slot_t a, input slot_t b, input logic [4:0] sh,
                               input logic neg, input logic dbl);
    term_t t;
    t.en  = 1'b1;
    t.a   = a;
    t.b   = b;
    t.sh  = sh;
    t.neg = neg;
    t.dbl = dbl;
    return t;
  endfunction

  function automatic op_t mk_op(input term_t t0, input term_t t1, input term_t t2,
                                input logic [4:0] psh, input logic pneg, input slot_t add,
                                input logic aneg, input logic one, input slot_t dst);
    op_t o;
    o.t[0]     = t0;
    o.t[1]     = t1;
    o.t[2]     = t2;
    o.post_sh  = psh;
    o.post_neg = pneg;
    o.add      = add;
    o.add_neg  = aneg;
    o.add_one  = one;
    o.dst      = dst;
    return o;
  endfunction

  // microcode: error function, gradient, gyro rate, rate derivative, integration
  function automatic op_t op_rom(input logic [4:0] idx);
    op_t o;
    case (idx)
      5'd0: o = mk_op(tm(SL_QX, SL_QZ, 5'd0, 1'b0, 1'b0), tm(SL_QW, SL_QY, 5'd0, 1'b1, 1'b0),
                      TNONE, 5'd29, 1'b0, SL_A0, 1'b1, 1'b0, SL_F1);
      5'd1: o = mk_op(tm(SL_QW, SL_QX, 5'd0, 1'b0, 1'b0), tm(SL_QY, SL_QZ, 5'd0, 1'b0, 1'b0),
                      TNONE, 5'd29, 1'b0, SL_A1, 1'b1, 1'b0, SL_F2);
      5'd2: o = mk_op(tm(SL_QX, SL_QX, 5'd0, 1'b0, 1'b0), tm(SL_QY, SL_QY, 5'd0, 1'b0, 1'b0),
                      TNONE, 5'd29, 1'b1, SL_A2, 1'b1, 1'b1, SL_F3);
      5'd3: o = mk_op(tm(SL_QY, SL_F1, 5'd30, 1'b1, 1'b0), tm(SL_QX, SL_F2, 5'd30, 1'b0, 1'b0),
                      TNONE, 5'd0, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_S0);
      5'd4: o = mk_op(tm(SL_QZ, SL_F1, 5'd30, 1'b0, 1'b0), tm(SL_QW, SL_F2, 5'd30, 1'b0, 1'b0),
                      tm(SL_QX, SL_F3, 5'd30, 1'b1, 1'b1),
                      5'd0, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_S1);
      5'd5: o = mk_op(tm(SL_QW, SL_F1, 5'd30, 1'b1, 1'b0), tm(SL_QZ, SL_F2, 5'd30, 1'b0, 1'b0),
                      tm(SL_QY, SL_F3, 5'd30, 1'b1, 1'b1),
                      5'd0, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_S2);
      5'd6: o = mk_op(tm(SL_QX, SL_F1, 5'd30, 1'b0, 1'b0), tm(SL_QY, SL_F2, 5'd30, 1'b0, 1'b0),
                      TNONE, 5'd0, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_S3);
      5'd7: o = mk_op(tm(SL_QX, SL_GX, 5'd0, 1'b1, 1'b0), tm(SL_QY, SL_GY, 5'd0, 1'b1, 1'b0),
                      tm(SL_QZ, SL_GZ, 5'd0, 1'b1, 1'b0),
                      5'd21, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_R0);
      5'd8: o = mk_op(tm(SL_QW, SL_GX, 5'd0, 1'b0, 1'b0), tm(SL_QY, SL_GZ, 5'd0, 1'b0, 1'b0),
                      tm(SL_QZ, SL_GY, 5'd0, 1'b1, 1'b0),
                      5'd21, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_R1);
      5'd9: o = mk_op(tm(SL_QW, SL_GY, 5'd0, 1'b0, 1'b0), tm(SL_QX, SL_GZ, 5'd0, 1'b1, 1'b0),
                      tm(SL_QZ, SL_GX, 5'd0, 1'b0, 1'b0),
                      5'd21, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_R2);
      5'd10: o = mk_op(tm(SL_QW, SL_GZ, 5'd0, 1'b0, 1'b0), tm(SL_QX, SL_GY, 5'd0, 1'b0, 1'b0),
                       tm(SL_QY, SL_GX, 5'd0, 1'b1, 1'b0),
                       5'd21, 1'b0, SL_ZERO, 1'b0, 1'b0, SL_R3);
      5'd11: o = mk_op(tm(SL_BETA, SL_S0, 5'd16, 1'b1, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_R0, 1'b0, 1'b0, SL_D0);
      5'd12: o = mk_op(tm(SL_BETA, SL_S1, 5'd16, 1'b1, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_R1, 1'b0, 1'b0, SL_D1);
      5'd13: o = mk_op(tm(SL_BETA, SL_S2, 5'd16, 1'b1, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_R2, 1'b0, 1'b0, SL_D2);
      5'd14: o = mk_op(tm(SL_BETA, SL_S3, 5'd16, 1'b1, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_R3, 1'b0, 1'b0, SL_D3);
      5'd15: o = mk_op(tm(SL_D0, SL_PER, 5'd24, 1'b0, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_QW, 1'b0, 1'b0, SL_N0);
      5'd16: o = mk_op(tm(SL_D1, SL_PER, 5'd24, 1'b0, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_QX, 1'b0, 1'b0, slot_t'(SL_N0 + 5'd1));
      5'd17: o = mk_op(tm(SL_D2, SL_PER, 5'd24, 1'b0, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_QY, 1'b0, 1'b0, slot_t'(SL_N0 + 5'd2));
      5'd18: o = mk_op(tm(SL_D3, SL_PER, 5'd24, 1'b0, 1'b0), TNONE, TNONE,
                       5'd0, 1'b0, SL_QZ, 1'b0, 1'b0, slot_t'(SL_N0 + 5'd3));
      default: o = '0;
    endcase
    return o;
  endfunction

endpackage

### src/iqfs_if.sv
interface iqfs_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] rate_x;
  logic signed [23:0] rate_y;
  logic signed [23:0] rate_z;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                  input ready);
  modport sink (input valid, rate_x, rate_y, rate_z, accel_x, accel_y, accel_z,
                output ready);
endinterface

interface iqfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] quat_w;
  logic signed [31:0] quat_x;
  logic signed [31:0] quat_y;
  logic signed [31:0] quat_z;
  logic               accel_invalid;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, accel_invalid,
                  input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, accel_invalid,
                output ready);
endinterface

interface iqfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/imu_quaternion_fusion_step.sv
// A valid sample is fully processed before its result is queued; a sample whose
// acceleration is all zero skips the unit-vector and microcode steps.
// The block takes one sample at a time; the next sample is taken once the result is queued.
// Run time is set by the root and the divide per component, used for three unit vectors,
// by the normalising shifts of each unit vector, and by the microcode ops.
module imu_quaternion_fusion_step (
  input logic        clk,
  input logic        rst_n,
  iqfs_in_if.sink    in_if,
  iqfs_out_if.source out_if,
  iqfs_cfg_if.sink   cfg_if
);
  import iqfs_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_UVA  = 3'd1;
  localparam logic [2:0] P_OPS1 = 3'd2;
  localparam logic [2:0] P_UVG  = 3'd3;
  localparam logic [2:0] P_OPS2 = 3'd4;
  localparam logic [2:0] P_UVN  = 3'd5;
  localparam logic [2:0] P_DONE = 3'd6;

  localparam logic [3:0] U_IDLE = 4'd0;
  localparam logic [3:0] U_LOAD = 4'd1;
  localparam logic [3:0] U_CHK  = 4'd2;
  localparam logic [3:0] U_NORM = 4'd3;
  localparam logic [3:0] U_SQ   = 4'd4;
  localparam logic [3:0] U_SQRT = 4'd5;
  localparam logic [3:0] U_SQW  = 4'd6;
  localparam logic [3:0] U_DIV  = 4'd7;
  localparam logic [3:0] U_DIVW = 4'd8;
  localparam logic [3:0] U_END  = 4'd9;

  localparam logic [39:0] MAG_HI = 40'd1 << 30;
  localparam logic [39:0] MAG_LO = 40'd1 << 29;

  logic [2:0]         ph_r;
  logic [3:0]         us_r;
  logic [4:0]         op_r;
  logic [2:0]         tk_r;
  logic [2:0]         cnt_r;
  slot_t              src_r;
  slot_t              dst_r;
  logic [2:0]         n_r;
  logic               ok_r;
  logic               inv_r;
  logic signed [39:0] rf_r [NSLOT];
  logic [39:0]        mag_r [4];
  logic [3:0]         neg_r;
  logic signed [71:0] acc_r;
  logic [31:0]        root_r;

  logic               out_valid_r;
  logic signed [31:0] quat_w_r;
  logic signed [31:0] quat_x_r;
  logic signed [31:0] quat_y_r;
  logic signed [31:0] quat_z_r;
  logic               accel_invalid_r;

  op_t                op_c;
  term_t              t_iss;
  term_t              t_acc;
  logic signed [71:0] term_val;
  logic signed [71:0] post_val;
  logic signed [71:0] add_val;
  logic signed [39:0] ld_v [4];
  logic [39:0]        mx01;
  logic [39:0]        mx23;
  logic [39:0]        mx;
  logic signed [35:0] mul_a;
  logic signed [35:0] mul_b;
  logic signed [71:0] mul_p;
  unit_ctl_t          sq_in;
  unit_ctl_t          sq_out;
  unit_ctl_t          dv_in;
  unit_ctl_t          dv_out;
  logic [31:0]        sq_root;
  logic [30:0]        dv_quo;
  logic signed [39:0] dv_signed;

  assign op_c  = op_rom(op_r);
  assign t_iss = (tk_r == 3'd0) ? op_c.t[0] : (tk_r == 3'd1) ? op_c.t[1] : op_c.t[2];
  assign t_acc = (tk_r == 3'd1) ? op_c.t[0] : (tk_r == 3'd2) ? op_c.t[1] : op_c.t[2];

  always_comb begin
    term_val = rshr72(mul_p, t_acc.sh);
    if (t_acc.dbl) begin
      term_val = term_val <<< 1;
    end
    if (t_acc.neg) begin
      term_val = -term_val;
    end
    add_val  = {{32{rf_r[op_c.add][39]}}, rf_r[op_c.add]};
    post_val = rshr72(acc_r, op_c.post_sh);
    if (op_c.post_neg) begin
      post_val = -post_val;
    end
    if (op_c.add_neg) begin
      post_val = post_val - add_val;
    end else begin
      post_val = post_val + add_val;
    end
    if (op_c.add_one) begin
      post_val = post_val + (72'sd1 <<< 30);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ld_v[i] = rf_r[slot_t'(src_r + slot_t'(i))];
    end
  end

  assign mx01 = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign mx23 = (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
  assign mx   = (mx01 > mx23) ? mx01 : mx23;

  always_comb begin
    if (us_r == U_SQ) begin
      mul_a = $signed({1'b0, mag_r[cnt_r[1:0]][34:0]});
      mul_b = $signed({1'b0, mag_r[cnt_r[1:0]][34:0]});
    end else begin
      mul_a = rf_r[t_iss.a][35:0];
      mul_b = rf_r[t_iss.b][35:0];
    end
  end

  assign sq_in.start = (us_r == U_SQRT);
  assign sq_in.done  = 1'b0;
  assign dv_in.start = (us_r == U_DIV);
  assign dv_in.done  = 1'b0;
  assign dv_signed   = neg_r[cnt_r[1:0]] ? -$signed({9'd0, dv_quo}) : $signed({9'd0, dv_quo});

  iqfs_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  iqfs_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (sq_in),
    .ctl_out (sq_out),
    .x       (acc_r[63:0]),
    .root    (sq_root)
  );

  iqfs_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (dv_in),
    .ctl_out (dv_out),
    .mag     (mag_r[cnt_r[1:0]][29:0]),
    .den     (root_r),
    .quo     (dv_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r        <= P_IDLE;
      us_r        <= U_IDLE;
      op_r        <= '0;
      tk_r        <= '0;
      cnt_r       <= '0;
      ok_r        <= 1'b0;
      inv_r       <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_t'(i) == SL_QW) begin
          rf_r[i] <= 40'sd1 <<< 30;
        end else if (slot_t'(i) == SL_BETA) begin
          rf_r[i] <= $signed({24'd0, BETA_RST});
        end else if (slot_t'(i) == SL_PER) begin
          rf_r[i] <= $signed({16'd0, PERIOD_RST});
        end else begin
          rf_r[i] <= '0;
        end
      end
    end else begin
      if (cfg_if.valid) begin
        case (cfg_if.index)
          REG_GAIN_BETA:     rf_r[SL_BETA] <= $signed({24'd0, cfg_if.data[15:0]});
          REG_SAMPLE_PERIOD: rf_r[SL_PER]  <= $signed({16'd0, cfg_if.data[23:0]});
          default: ;
        endcase
      end
      if (ph_r == P_DONE && (!out_valid_r || out_if.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_if.ready) begin
        out_valid_r <= 1'b0;
      end

      case (ph_r)
        P_IDLE: begin
          if (in_if.valid) begin
            rf_r[SL_GX] <= {{16{in_if.rate_x[23]}}, in_if.rate_x};
            rf_r[SL_GY] <= {{16{in_if.rate_y[23]}}, in_if.rate_y};
            rf_r[SL_GZ] <= {{16{in_if.rate_z[23]}}, in_if.rate_z};
            rf_r[SL_AX] <= {{24{in_if.accel_x[15]}}, in_if.accel_x};
            rf_r[SL_AY] <= {{24{in_if.accel_y[15]}}, in_if.accel_y};
            rf_r[SL_AZ] <= {{24{in_if.accel_z[15]}}, in_if.accel_z};
            inv_r <= 1'b0;
            src_r <= SL_AX;
            dst_r <= SL_A0;
            n_r   <= 3'd3;
            us_r  <= U_LOAD;
            ph_r  <= P_UVA;
          end
        end

        P_OPS1, P_OPS2: begin
          // term k issued at tk=k, its product accumulated in the next cycle, at tk=k+1
          if (tk_r != 3'd0 && tk_r != 3'd4 && t_acc.en) begin
            acc_r <= acc_r + term_val;
          end
          if (tk_r == 3'd4) begin
            rf_r[op_c.dst] <= post_val[39:0];
            acc_r <= '0;
            tk_r  <= '0;
            if (op_r == OP_LAST1) begin
              src_r <= SL_S0;
              dst_r <= SL_S0;
              n_r   <= 3'd4;
              us_r  <= U_LOAD;
              ph_r  <= P_UVG;
            end else if (op_r == OP_LAST2) begin
              src_r <= SL_N0;
              dst_r <= SL_QW;
              n_r   <= 3'd4;
              us_r  <= U_LOAD;
              ph_r  <= P_UVN;
            end else begin
              op_r <= op_r + 5'd1;
            end
          end else begin
            tk_r <= tk_r + 3'd1;
          end
        end

        P_UVA, P_UVG, P_UVN: begin
          case (us_r)
            U_LOAD: begin
              for (int i = 0; i < 4; i++) begin
                if (3'(i) < n_r) begin
                  mag_r[i] <= ld_v[i][39] ? 40'(-ld_v[i]) : 40'(ld_v[i]);
                  neg_r[i] <= ld_v[i][39];
                end else begin
                  mag_r[i] <= '0;
                  neg_r[i] <= 1'b0;
                end
              end
              us_r <= U_CHK;
            end
            U_CHK: begin
              acc_r <= '0;
              cnt_r <= '0;
              if (mx == '0) begin
                ok_r <= 1'b0;
                us_r <= U_END;
              end else begin
                us_r <= U_NORM;
              end
            end
            U_NORM: begin
              if (mx >= MAG_HI) begin
                for (int i = 0; i < 4; i++) begin
                  mag_r[i] <= mag_r[i] >> 1;
                end
              end else if (mx < MAG_LO) begin
                for (int i = 0; i < 4; i++) begin
                  mag_r[i] <= mag_r[i] << 1;
                end
              end else begin
                us_r <= U_SQ;
              end
            end
            U_SQ: begin
              if (cnt_r != 3'd0) begin
                acc_r <= acc_r + mul_p;
              end
              if (cnt_r == 3'd4) begin
                cnt_r <= '0;
                us_r  <= U_SQRT;
              end else begin
                cnt_r <= cnt_r + 3'd1;
              end
            end
            U_SQRT: begin
              us_r <= U_SQW;
            end
            U_SQW: begin
              if (sq_out.done) begin
                root_r <= sq_root;
                us_r   <= U_DIV;
              end
            end
            U_DIV: begin
              us_r <= U_DIVW;
            end
            U_DIVW: begin
              if (dv_out.done) begin
                rf_r[slot_t'(dst_r + slot_t'(cnt_r))] <= dv_signed;
                if (3'(cnt_r + 3'd1) == n_r) begin
                  ok_r <= 1'b1;
                  us_r <= U_END;
                end else begin
                  cnt_r <= cnt_r + 3'd1;
                  us_r  <= U_DIV;
                end
              end
            end
            U_END: begin
              us_r  <= U_IDLE;
              acc_r <= '0;
              tk_r  <= '0;
              if (ph_r == P_UVA) begin
                if (ok_r) begin
                  op_r <= '0;
                  ph_r <= P_OPS1;
                end else begin
                  inv_r <= 1'b1;
                  ph_r  <= P_DONE;
                end
              end else if (ph_r == P_UVG) begin
                // zero gradient gives zero correction
                if (!ok_r) begin
                  rf_r[SL_S0] <= '0;
                  rf_r[SL_S1] <= '0;
                  rf_r[SL_S2] <= '0;
                  rf_r[SL_S3] <= '0;
                end
                op_r <= OP_FIRST2;
                ph_r <= P_OPS2;
              end else begin
                ph_r <= P_DONE;
              end
            end
            default: us_r <= U_IDLE;
          endcase
        end

        P_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            quat_w_r        <= rf_r[SL_QW][31:0];
            quat_x_r        <= rf_r[SL_QX][31:0];
            quat_y_r        <= rf_r[SL_QY][31:0];
            quat_z_r        <= rf_r[SL_QZ][31:0];
            accel_invalid_r <= inv_r;
            ph_r            <= P_IDLE;
          end
        end

        default: ph_r <= P_IDLE;
      endcase
    end
  end

  assign in_if.ready          = (ph_r == P_IDLE);
  assign cfg_if.ready         = 1'b1;
  assign out_if.valid         = out_valid_r;
  assign out_if.quat_w        = quat_w_r;
  assign out_if.quat_x        = quat_x_r;
  assign out_if.quat_y        = quat_y_r;
  assign out_if.quat_z        = quat_z_r;
  assign out_if.accel_invalid = accel_invalid_r;
endmodule

### src/iqfs_mul.sv
module iqfs_mul (
  input  logic               clk,
  input  logic signed [35:0] a,
  input  logic signed [35:0] b,
  output logic signed [71:0] p
);
  logic signed [71:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;
endmodule

### src/iqfs_sqrt.sv
module iqfs_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  iqfs_pkg::unit_ctl_t     ctl_in,
  output iqfs_pkg::unit_ctl_t     ctl_out,
  input  logic [63:0]             x,
  output logic [31:0]             root
);
  import iqfs_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;

  // one result bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        x_r    <= x;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r == 64'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl_out.start = busy_r;
  assign ctl_out.done  = done_r;
  assign root          = res_r[31:0];
endmodule

### src/iqfs_div.sv
module iqfs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  iqfs_pkg::unit_ctl_t ctl_in,
  output iqfs_pkg::unit_ctl_t ctl_out,
  input  logic [29:0]         mag,
  input  logic [31:0]         den,
  output logic [30:0]         quo
);
  import iqfs_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [31:0] rem_r;
  logic [30:0] num_r;
  logic [30:0] quo_r;
  logic [31:0] den_r;
  logic [4:0]  cnt_r;
  logic [32:0] trial;
  logic [32:0] diff;

  // (mag << 30) / den, quotient known to fit 31 bits, so the top 29 dividend
  // bits seed the remainder
  assign trial = {rem_r, num_r[30]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        rem_r  <= {3'd0, mag[29:1]};
        num_r  <= {mag[0], 30'd0};
        quo_r  <= '0;
        den_r  <= den;
        cnt_r  <= 5'd30;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (trial >= {1'b0, den_r}) begin
          rem_r <= diff[31:0];
          quo_r <= {quo_r[29:0], 1'b1};
        end else begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[29:0], 1'b0};
        end
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl_out.start = busy_r;
  assign ctl_out.done  = done_r;
  assign quo           = quo_r;
endmodule

### src/iqfs_checker.sv
`include "imu_quaternion_fusion_step_defines.svh"

module iqfs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] quat_w,
  input logic signed [31:0] quat_x,
  input logic signed [31:0] quat_y,
  input logic signed [31:0] quat_z
);

  // result held until taken
  `IQFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(quat_w), "result dropped or changed while stalled")

  // one sample in flight at a time
  `IQFS_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken during processing")

  // every reported component is a unit-vector component or the identity
  `IQFS_ASSERT_NOW(a_wx_bound, out_valid, quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824 && quat_x <= 32'sd1073741824 && quat_x >= -32'sd1073741824, "w or x out of range")

  `IQFS_ASSERT_NOW(a_yz_bound, out_valid, quat_y <= 32'sd1073741824 && quat_y >= -32'sd1073741824 && quat_z <= 32'sd1073741824 && quat_z >= -32'sd1073741824, "y or z out of range")

endmodule

bind imu_quaternion_fusion_step iqfs_checker u_iqfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .quat_w    (out_if.quat_w),
  .quat_x    (out_if.quat_x),
  .quat_y    (out_if.quat_y),
  .quat_z    (out_if.quat_z)
);
